### rtl/core/multi_slot_task_timer_unit_macros.svh
// Assertion macros shared by the timer unit checker
`ifndef MULTI_SLOT_TASK_TIMER_UNIT_MACROS_SVH
`define MULTI_SLOT_TASK_TIMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MSTT_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer unit check failed");

// Next-cycle implication, disabled during reset
`define MSTT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer unit check failed");

`endif

### rtl/core/mstt_pkg.sv
// Types, constants and helpers for the multi-slot task timer unit
`timescale 1ns / 1ps
package mstt_pkg;

   localparam int NUM_SLOTS  = 8;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);
   localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
   localparam int RESULT_CAP = 8;
   localparam int REP_W      = $clog2(RESULT_CAP + 1);
   localparam int DELAY_W    = 24;
   localparam int TASK_W     = 8;

   localparam logic [DELAY_W-1:0] CHUNK   = 24'd16383;
   localparam logic [CNT_W-1:0]   ISS_END = CNT_W'(NUM_SLOTS);
   localparam logic [REP_W-1:0]   REP_CAP = REP_W'(RESULT_CAP);

   typedef enum logic [1:0] {
      REQ_ADD  = 2'd0,
      REQ_LONG = 2'd1,
      REQ_TICK = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_ACCEPT = 2'd0,
      KIND_REJECT = 2'd1,
      KIND_FIRED  = 2'd2,
      KIND_IDLE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [DELAY_W-1:0] delay_ticks;
      logic [TASK_W-1:0]  task_id;
   } mstt_req_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic [2:0]        slot_index;
      logic [TASK_W-1:0] fired_task;
      logic              last;
   } mstt_rsp_type;

   // One slot as kept in the slot memory
   typedef struct packed {
      logic [DELAY_W-1:0] count;
      logic [TASK_W-1:0]  task_id;
      logic               chain;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   // Lowest free slot search result
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] idx;
   } alloc_type;

   // Reported slot number keeps its low three bits
   function automatic logic [2:0] slot_index_of(logic [SLOT_W-1:0] slot);
      logic [SLOT_W+2:0] wide;
      wide = {3'b000, slot};
      return wide[2:0];
   endfunction

endpackage

### rtl/core/mstt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
`timescale 1ns / 1ps
module mstt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/mstt_alloc.sv
// Lowest free slot finder
`timescale 1ns / 1ps
module mstt_alloc (
   input  logic [mstt_pkg::NUM_SLOTS-1:0] free_vec,
   output mstt_pkg::alloc_type            result
);
   import mstt_pkg::*;

   // Scan from the top so the lowest free slot wins
   always_comb begin
      result.found = 1'b0;
      result.idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            result.found = 1'b1;
            result.idx   = SLOT_W'(i);
         end
      end
   end

endmodule

### rtl/core/multi_slot_task_timer_unit.sv
// Top level of the multi-slot task timer unit
//
//  Channel  Direction  Handshake              Payload
//  req_     in         req_valid / req_stall  mstt_req_type (req_type, delay_ticks, task_id)
//  rsp_     out        rsp_valid / rsp_stall  mstt_rsp_type (result_kind, slot_index,
//                                             fired_task, last)
//
// An add is accepted, then searches the busy bits and writes the slot in the add state.
// A tick walks the slots, reading one slot per cycle from the slot memory unless a stalled
// result holds the walk and writing back each entry that it decrements; the final result
// leaves from the done state. Items are taken one at a time. Reset is synchronous and
// clears all busy bits and the chain state; the slot memory needs no clearing. A stalled
// result port holds the walk only when another fired result has to leave.
`timescale 1ns / 1ps
module multi_slot_task_timer_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mstt_pkg::mstt_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mstt_pkg::mstt_rsp_type rsp_data
);
   import mstt_pkg::*;

   state_type               state_ff, state_in;
   mstt_req_type            req_ff, req_in;
   logic [NUM_SLOTS-1:0]    busy_ff, busy_in;
   logic [TASK_W-1:0]       chain_target_ff, chain_target_in;
   logic [DELAY_W-1:0]      chain_rem_ff, chain_rem_in;
   logic                    chain_active_ff, chain_active_in;
   logic [CNT_W-1:0]        iss_ff, iss_in;
   logic                    proc_v_ff, proc_v_in;
   logic [SLOT_W-1:0]       proc_idx_ff, proc_idx_in;
   logic                    fwd_v_ff, fwd_v_in;
   slot_entry_type          fwd_data_ff, fwd_data_in;
   logic                    held_v_ff, held_v_in;
   logic [SLOT_W-1:0]       held_slot_ff, held_slot_in;
   logic [TASK_W-1:0]       held_task_ff, held_task_in;
   logic [REP_W-1:0]        rep_ff, rep_in;
   logic                    out_v_ff, out_v_in;
   mstt_rsp_type            out_data_ff, out_data_in;

   logic                    accept;
   logic                    out_free;
   logic                    walk_stall;
   logic                    walk_go;
   logic                    add_go;
   slot_entry_type          cur;
   logic                    proc_busy;
   logic                    p_dec, p_exp, p_fire, p_report, p_emit;
   logic                    rearm, final_add, place_req;
   slot_entry_type          place_entry;
   logic [DELAY_W-1:0]      a_delay;
   logic                    a_long, a_try;
   slot_entry_type          a_entry;
   logic [NUM_SLOTS-1:0]    clr_mask;
   alloc_type               alloc;
   logic                    ram_we, ram_re;
   logic [SLOT_W-1:0]       ram_waddr, ram_raddr;
   slot_entry_type          ram_wdata;
   logic [ENTRY_W-1:0]      ram_rdata;
   logic                    push;
   mstt_rsp_type            push_data;

   mstt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   mstt_alloc u_alloc (
      .free_vec (~busy_ff | clr_mask),
      .result   (alloc)
   );

   assign accept   = req_valid && !req_stall;
   assign out_free = !out_v_ff || !rsp_stall;

   // Decode the slot under the walk; forwarded data covers a same-cycle write
   always_comb begin
      cur       = fwd_v_ff ? fwd_data_ff : slot_entry_type'(ram_rdata);
      proc_busy = (state_ff == ST_WALK) && proc_v_ff && busy_ff[proc_idx_ff];
      p_dec     = proc_busy && (cur.count > 24'd1);
      p_exp     = proc_busy && !p_dec;
      p_fire    = p_exp && !cur.chain;
      p_report  = p_fire && (rep_ff < REP_CAP);
      p_emit    = p_report && held_v_ff;
      rearm     = p_exp && cur.chain && (chain_rem_ff > CHUNK);
      final_add = p_exp && cur.chain && !rearm && (chain_rem_ff != '0);
      place_req = rearm || (final_add && (chain_target_ff != '0));
      clr_mask  = '0;
      if (p_exp) begin
         clr_mask[proc_idx_ff] = 1'b1;
      end
      if (rearm) begin
         place_entry = '{count: CHUNK, task_id: '0, chain: 1'b1};
      end else begin
         place_entry = '{count: chain_rem_ff, task_id: chain_target_ff, chain: 1'b0};
      end
   end

   // Decode the registered add request
   always_comb begin
      a_delay = (req_ff.delay_ticks == '0) ? 24'd1 : req_ff.delay_ticks;
      a_long  = (req_ff.req_type == REQ_LONG) && (a_delay > CHUNK);
      a_try   = (req_ff.task_id != '0) && !(a_long && chain_active_ff);
      if (a_long) begin
         a_entry = '{count: CHUNK, task_id: '0, chain: 1'b1};
      end else begin
         a_entry = '{count: a_delay, task_id: req_ff.task_id, chain: 1'b0};
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  REQ_ADD, REQ_LONG: state_in = ST_ADD;
                  REQ_TICK:          state_in = ST_WALK;
                  default:           state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (!walk_stall && (iss_ff == ISS_END)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      walk_stall = p_emit && !out_free;
      walk_go    = (state_ff == ST_WALK) && !walk_stall;
      add_go     = (state_ff == ST_ADD) && out_free;
   end

   // Slot memory access, busy bits, chain state and results
   always_comb begin
      req_in          = req_ff;
      busy_in         = busy_ff;
      chain_target_in = chain_target_ff;
      chain_rem_in    = chain_rem_ff;
      chain_active_in = chain_active_ff;
      iss_in          = iss_ff;
      proc_v_in       = proc_v_ff;
      proc_idx_in     = proc_idx_ff;
      fwd_v_in        = fwd_v_ff;
      fwd_data_in     = fwd_data_ff;
      held_v_in       = held_v_ff;
      held_slot_in    = held_slot_ff;
      held_task_in    = held_task_ff;
      rep_in          = rep_ff;
      ram_we          = 1'b0;
      ram_waddr       = alloc.idx;
      ram_wdata       = a_entry;
      ram_re          = 1'b0;
      ram_raddr       = iss_ff[SLOT_W-1:0];
      push            = 1'b0;
      push_data       = '{result_kind: KIND_REJECT, slot_index: '0, fired_task: '0,
                          last: 1'b1};

      // Capture a new transaction and clear the walk bookkeeping
      if (accept) begin
         req_in    = req_data;
         iss_in    = '0;
         held_v_in = 1'b0;
         rep_in    = '0;
      end

      // Place an add in the lowest free slot
      if (add_go) begin
         push = 1'b1;
         if (a_try && alloc.found) begin
            ram_we         = 1'b1;
            ram_wdata      = a_entry;
            busy_in[alloc.idx] = 1'b1;
            push_data.result_kind = KIND_ACCEPT;
            push_data.slot_index  = slot_index_of(alloc.idx);
            if (a_long) begin
               chain_target_in = req_ff.task_id;
               chain_rem_in    = a_delay - CHUNK;
               chain_active_in = 1'b1;
            end
         end
      end

      if (walk_go) begin
         // Issue the next slot read; forward a write that hits it
         proc_v_in = 1'b0;
         if (iss_ff != ISS_END) begin
            ram_re      = 1'b1;
            iss_in      = iss_ff + CNT_W'(1);
            proc_v_in   = 1'b1;
            proc_idx_in = iss_ff[SLOT_W-1:0];
         end

         // Decrement, or free an expired slot
         if (p_dec) begin
            ram_we    = 1'b1;
            ram_waddr = proc_idx_ff;
            ram_wdata = '{count: cur.count - 24'd1, task_id: cur.task_id, chain: cur.chain};
         end else if (p_exp) begin
            busy_in[proc_idx_ff] = 1'b0;
         end

         // Re-arm or finish the chain
         if (rearm) begin
            chain_rem_in = chain_rem_ff - CHUNK;
         end else if (final_add) begin
            chain_rem_in    = '0;
            chain_target_in = '0;
            chain_active_in = 1'b0;
         end
         if (place_req && alloc.found) begin
            ram_we             = 1'b1;
            ram_waddr          = alloc.idx;
            ram_wdata          = place_entry;
            busy_in[alloc.idx] = 1'b1;
         end

         if (ram_re) begin
            fwd_v_in    = ram_we && (ram_waddr == ram_raddr);
            fwd_data_in = ram_wdata;
         end

         // Release the held fire and hold the new one
         if (p_emit) begin
            push      = 1'b1;
            push_data = '{result_kind: KIND_FIRED, slot_index: slot_index_of(held_slot_ff),
                          fired_task: held_task_ff, last: 1'b0};
         end
         if (p_report) begin
            held_v_in    = 1'b1;
            held_slot_in = proc_idx_ff;
            held_task_in = cur.task_id;
            rep_in       = rep_ff + REP_W'(1);
         end
      end

      // Close the tick
      if ((state_ff == ST_DONE) && out_free) begin
         push = 1'b1;
         if (held_v_ff) begin
            push_data = '{result_kind: KIND_FIRED, slot_index: slot_index_of(held_slot_ff),
                          fired_task: held_task_ff, last: 1'b1};
         end else begin
            push_data = '{result_kind: KIND_IDLE, slot_index: '0, fired_task: '0,
                          last: 1'b1};
         end
         held_v_in = 1'b0;
      end
   end

   // Output register
   always_comb begin
      out_data_in = out_data_ff;
      out_v_in    = out_v_ff && rsp_stall;
      if (push) begin
         out_v_in    = 1'b1;
         out_data_in = push_data;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_data_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         busy_ff         <= '0;
         chain_target_ff <= '0;
         chain_rem_ff    <= '0;
         chain_active_ff <= 1'b0;
         iss_ff          <= '0;
         proc_v_ff       <= 1'b0;
         fwd_v_ff        <= 1'b0;
         held_v_ff       <= 1'b0;
         rep_ff          <= '0;
         out_v_ff        <= 1'b0;
      end else begin
         state_ff        <= state_in;
         busy_ff         <= busy_in;
         chain_target_ff <= chain_target_in;
         chain_rem_ff    <= chain_rem_in;
         chain_active_ff <= chain_active_in;
         iss_ff          <= iss_in;
         proc_v_ff       <= proc_v_in;
         fwd_v_ff        <= fwd_v_in;
         held_v_ff       <= held_v_in;
         rep_ff          <= rep_in;
         out_v_ff        <= out_v_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      proc_idx_ff  <= proc_idx_in;
      fwd_data_ff  <= fwd_data_in;
      held_slot_ff <= held_slot_in;
      held_task_ff <= held_task_in;
      out_data_ff  <= out_data_in;
   end

endmodule

### rtl/core/mstt_checker.sv
// Port-level checker for the multi-slot task timer unit, with its bind
`timescale 1ns / 1ps
`include "multi_slot_task_timer_unit_macros.svh"
module mstt_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input mstt_pkg::mstt_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input mstt_pkg::mstt_rsp_type rsp_data
);
   import mstt_pkg::*;

   logic rsp_held;
   logic req_taken;
   logic rsp_plain;
   logic rsp_fired;
   logic rsp_other;
   logic no_task;
   logic no_slot;

   // Decode the port activity the checks look at
   assign rsp_held  = rsp_valid && rsp_stall;
   assign req_taken = req_valid && !req_stall &&
                      (req_data.req_type inside {REQ_ADD, REQ_LONG, REQ_TICK});
   assign rsp_plain = rsp_valid && (rsp_data.result_kind inside {KIND_REJECT, KIND_IDLE});
   assign rsp_fired = rsp_valid && (rsp_data.result_kind == KIND_FIRED);
   assign rsp_other = rsp_valid && (rsp_data.result_kind != KIND_FIRED);
   assign no_task   = (rsp_data.fired_task == '0);
   assign no_slot   = (rsp_data.slot_index == 3'd0);

   // A stalled result holds
   `MSTT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))

   // One transaction at a time: a real request closes the input
   `MSTT_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_taken, req_stall)

   // Reject and empty-tick results carry no slot and no task
   `MSTT_ASSERT_NOW(a_empty_fields, clock, reset, rsp_plain, no_slot && no_task && rsp_data.last)

   // Fired results name a real task
   `MSTT_ASSERT_NOW(a_fired_task, clock, reset, rsp_fired, !no_task)

   // Add and empty-tick results are single and carry no task
   `MSTT_ASSERT_NOW(a_single_result, clock, reset, rsp_other, no_task && rsp_data.last)

endmodule

bind multi_slot_task_timer_unit mstt_checker u_mstt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
